// ----- sv/cefs_pkg.sv -----
// Shared types, constants and digit helpers for the charger equalize/float sequencer.
// Used by cefs_mac and charger_equalize_float_sequencer_top; depends on nothing.
package cefs_pkg;

  localparam int SLOTS        = 10;
  localparam int SETTLE_TICKS = 10;
  localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCAN_W       = $clog2(SLOTS + 1);
  localparam int SETTLE_W     = $clog2(SETTLE_TICKS + 1);

  localparam int DIGITS       = 4;
  localparam int ACC_W        = 24;
  localparam int OPND_W       = 16;
  localparam int COEF_W       = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int IN_DATA_W    = 88;
  localparam int OUT_DATA_W   = 24;
  localparam int SETPT_W      = 15;

  localparam logic [SETPT_W-1:0] SETPOINT_MAX = 15'd16665;
  localparam logic [7:0]         ASCII_ZERO   = 8'h30;
  localparam logic signed [COEF_W-1:0] VOLT_PCT = 11'sd100;
  localparam logic signed [COEF_W-1:0] EQ_PCT_N = -11'sd98;

  localparam logic [1:0] PHASE_RESTART  = 2'd0;
  localparam logic [1:0] PHASE_EQUALIZE = 2'd1;
  localparam logic [1:0] PHASE_FLOAT    = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_SELECT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EQUALIZE_BCD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT_BCD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_ASCII  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_CURRENT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CUT_TIME      = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EQ,
    S_VCMP,
    S_DECIDE,
    S_SETPT,
    S_DONE
  } state_t;

  // One schedule slot, 33 bits.
  typedef struct packed {
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } sched_entry_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic                     en;
    logic                     clr;
    logic signed [OPND_W-1:0] operand;
    logic signed [COEF_W-1:0] coef;
  } mac_ctl_t;

  // Nibble k of a BCD word, most significant first.
  function automatic logic [3:0] nibble_at(input logic [15:0] v, input logic [1:0] k);
    logic [3:0] n;
    unique case (k)
      2'd0: n = v[15:12];
      2'd1: n = v[11:8];
      2'd2: n = v[7:4];
      2'd3: n = v[3:0];
    endcase
    return n;
  endfunction

  // Byte k of an ASCII word, most significant first.
  function automatic logic [7:0] byte_at(input logic [31:0] v, input logic [1:0] k);
    logic [7:0] b;
    unique case (k)
      2'd0: b = v[31:24];
      2'd1: b = v[23:16];
      2'd2: b = v[15:8];
      2'd3: b = v[7:0];
    endcase
    return b;
  endfunction

  // Decimal weight of digit k, in tenths of a volt.
  function automatic logic signed [COEF_W-1:0] digit_weight(input logic [1:0] k);
    logic signed [COEF_W-1:0] w;
    unique case (k)
      2'd0: w = 11'sd1000;
      2'd1: w = 11'sd100;
      2'd2: w = 11'sd10;
      2'd3: w = 11'sd1;
    endcase
    return w;
  endfunction

endpackage

// ----- sv/charger_equalize_float_sequencer_top.sv -----
// Top level of the charger equalize/float sequencer: schedule memory, sequencer,
// configuration registers and result register. Depends on cefs_pkg and cefs_mac.
//
//   channel  | direction | handshake         | payload
//   ---------+-----------+-------------------+----------------------------------
//   in_      | slave     | in_tvalid/tready  | in_tuser operation, in_tdata item
//   out_     | master    | out_tvalid/tready | out_tdata setpoint and mode flags
//   cfg_     | write     | cfg_we            | cfg_index, cfg_wdata
//
// Per item: a write item or a manual tick passes through accept, four digit
// steps of the MAC and result load; an automatic tick adds a schedule scan (one
// memory read per slot), and in the equalize phase a further equalize setpoint,
// 98% voltage compare and decision. The single MAC unit and the one-read-per-cycle
// schedule memory set the pace; a new item is taken only from the idle state.
// Reset (rst_n low, synchronous) clears the sequencing state and configuration;
// the schedule memory is not cleared and must be written before it is matched.
// in_tready is high only in the idle state; a finished result waits in the output
// register while the next item is taken, and the sequencer holds in its last
// state while that register is still full.
module charger_equalize_float_sequencer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [0] operation
  input  logic                                in_tuser,
  // [3:0] slot, [10:4] year, [14:11] month, [19:15] day, [24:20] hour,
  // [30:25] minute, [36:31] second, [52:37] battery_current,
  // [66:53] output_voltage, [82:67] eq_elapsed, [87:83] zero
  input  logic [cefs_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [14:0] setpoint_tenths, [15] manual_on, [16] float_on, [17] equalize_on,
  // [19:18] phase, [20] set_ok, [21] clear_timers, [23:22] zero
  output logic [cefs_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [cefs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cefs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  // Item fields in tdata order, first field in the high bits.
  typedef struct packed {
    logic [15:0] eq_elapsed;
    logic [13:0] output_voltage;
    logic [15:0] battery_current;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [6:0]  year;
    logic [3:0]  slot;
  } tick_item_t;

  localparam int ITEM_W = $bits(tick_item_t);
  localparam logic [1:0] STEP_LAST = 2'(cefs_pkg::DIGITS - 1);

  // ---------------------------------------------------------------- config
  logic        cfg_charge_select_r;
  logic        cfg_manual_enable_r;
  logic [15:0] cfg_equalize_bcd_r;
  logic [15:0] cfg_float_bcd_r;
  logic [31:0] cfg_manual_ascii_r;
  logic [15:0] cfg_cut_current_r;
  logic [15:0] cfg_cut_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_charge_select_r <= 1'b0;
      cfg_manual_enable_r <= 1'b0;
      cfg_equalize_bcd_r  <= '0;
      cfg_float_bcd_r     <= '0;
      cfg_manual_ascii_r  <= 32'h3030_3030;
      cfg_cut_current_r   <= '0;
      cfg_cut_time_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cefs_pkg::CFG_CHARGE_SELECT: cfg_charge_select_r <= cfg_wdata[0];
        cefs_pkg::CFG_MANUAL_ENABLE: cfg_manual_enable_r <= cfg_wdata[0];
        cefs_pkg::CFG_EQUALIZE_BCD:  cfg_equalize_bcd_r  <= cfg_wdata[15:0];
        cefs_pkg::CFG_FLOAT_BCD:     cfg_float_bcd_r     <= cfg_wdata[15:0];
        cefs_pkg::CFG_MANUAL_ASCII:  cfg_manual_ascii_r  <= cfg_wdata[31:0];
        cefs_pkg::CFG_CUT_CURRENT:   cfg_cut_current_r   <= cfg_wdata[15:0];
        cefs_pkg::CFG_CUT_TIME:      cfg_cut_time_r      <= cfg_wdata[15:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------- state
  cefs_pkg::state_t                  state_r, state_nxt;
  logic [1:0]                        step_r, step_nxt;
  logic [cefs_pkg::SCAN_W-1:0]       scan_r, scan_nxt;
  logic                              match_r, match_nxt;
  tick_item_t                        item_r, item_nxt;
  logic [1:0]                        phase_r, phase_nxt;
  logic                              mode_r, mode_nxt;
  logic [cefs_pkg::SETTLE_W-1:0]     settle_r, settle_nxt;
  logic                              set_ok_r, set_ok_nxt;
  logic                              clear_r, clear_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [cefs_pkg::OUT_DATA_W-1:0]   out_data_r, out_data_nxt;

  logic                              in_accept;
  tick_item_t                        in_item;
  cefs_pkg::sched_entry_t            sched_mem [cefs_pkg::SLOTS];
  cefs_pkg::sched_entry_t            rdata_r;
  logic                              slot_hit;
  logic                              scan_end;
  logic                              any_match;
  logic                              use_ascii;
  logic                              vok;
  logic                              cut_ok;
  logic [cefs_pkg::SETPT_W-1:0]      setpt_clamped;
  logic signed [cefs_pkg::ACC_W-1:0] acc;
  cefs_pkg::mac_ctl_t                mac_ctl;
  logic [7:0]                        ascii_byte;
  logic signed [8:0]                 ascii_digit;

  assign in_tready = (state_r == cefs_pkg::S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_item   = tick_item_t'(in_tdata[ITEM_W-1:0]);

  // ---------------------------------------------------------------- schedule memory
  always_ff @(posedge clk) begin
    if (in_accept && (in_tuser == cefs_pkg::OP_WRITE) &&
        (32'(in_item.slot) < 32'(cefs_pkg::SLOTS))) begin
      sched_mem[cefs_pkg::SLOT_W'(in_item.slot)] <= cefs_pkg::sched_entry_t'({
        in_item.year, in_item.month, in_item.day,
        in_item.hour, in_item.minute, in_item.second});
    end
  end

  // Read one slot per scan cycle; the compare uses it in the next cycle.
  always_ff @(posedge clk) begin
    if ((state_r == cefs_pkg::S_SCAN) && (scan_r < cefs_pkg::SCAN_W'(cefs_pkg::SLOTS))) begin
      rdata_r <= sched_mem[scan_r[cefs_pkg::SLOT_W-1:0]];
    end
  end

  // Zero in year, month or day of a slot is a wildcard.
  assign slot_hit = (scan_r != '0) &&
                    ((rdata_r.year  == item_r.year)  || (rdata_r.year  == '0)) &&
                    ((rdata_r.month == item_r.month) || (rdata_r.month == '0)) &&
                    ((rdata_r.day   == item_r.day)   || (rdata_r.day   == '0)) &&
                    (rdata_r.hour   == item_r.hour) &&
                    (rdata_r.minute == item_r.minute) &&
                    (rdata_r.second == item_r.second);
  assign scan_end  = (scan_r == cefs_pkg::SCAN_W'(cefs_pkg::SLOTS));
  assign any_match = match_r || slot_hit;

  // ---------------------------------------------------------------- shared MAC
  assign use_ascii   = cfg_charge_select_r && cfg_manual_enable_r;
  assign ascii_byte  = cefs_pkg::byte_at(cfg_manual_ascii_r, step_r);
  assign ascii_digit = $signed({1'b0, ascii_byte}) - $signed({1'b0, cefs_pkg::ASCII_ZERO});

  always_comb begin
    mac_ctl         = '0;
    mac_ctl.clr     = (step_r == 2'd0);
    mac_ctl.coef    = cefs_pkg::digit_weight(step_r);
    mac_ctl.operand = cefs_pkg::OPND_W'(cefs_pkg::nibble_at(cfg_equalize_bcd_r, step_r));
    unique case (state_r)
      cefs_pkg::S_EQ: begin
        mac_ctl.en = 1'b1;
      end
      cefs_pkg::S_VCMP: begin
        // Step 0: acc = -98 * equalize setpoint; step 1: add 100 * voltage.
        mac_ctl.en = 1'b1;
        if (step_r == 2'd0) begin
          mac_ctl.operand = $signed(acc[cefs_pkg::OPND_W-1:0]);
          mac_ctl.coef    = cefs_pkg::EQ_PCT_N;
        end else begin
          mac_ctl.operand = cefs_pkg::OPND_W'(item_r.output_voltage);
          mac_ctl.coef    = cefs_pkg::VOLT_PCT;
        end
      end
      cefs_pkg::S_SETPT: begin
        mac_ctl.en = 1'b1;
        if (use_ascii) begin
          mac_ctl.operand = cefs_pkg::OPND_W'(ascii_digit);
        end else if (mode_r) begin
          mac_ctl.operand = cefs_pkg::OPND_W'(cefs_pkg::nibble_at(cfg_float_bcd_r, step_r));
        end
      end
      default: ;
    endcase
  end

  cefs_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  assign vok    = (acc > 0);
  assign cut_ok = ((item_r.battery_current <= cfg_cut_current_r) && vok) ||
                  (item_r.eq_elapsed >= cfg_cut_time_r);

  // Saturate the setpoint sum to 0..SETPOINT_MAX.
  always_comb begin
    if (acc < 0) begin
      setpt_clamped = '0;
    end else if (acc > cefs_pkg::ACC_W'(cefs_pkg::SETPOINT_MAX)) begin
      setpt_clamped = cefs_pkg::SETPOINT_MAX;
    end else begin
      setpt_clamped = acc[cefs_pkg::SETPT_W-1:0];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cefs_pkg::S_IDLE;
      step_r      <= '0;
      scan_r      <= '0;
      match_r     <= 1'b0;
      phase_r     <= cefs_pkg::PHASE_RESTART;
      mode_r      <= 1'b0;
      settle_r    <= '0;
      set_ok_r    <= 1'b0;
      clear_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      scan_r      <= scan_nxt;
      match_r     <= match_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      settle_r    <= settle_nxt;
      set_ok_r    <= set_ok_nxt;
      clear_r     <= clear_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    scan_nxt      = scan_r;
    match_nxt     = match_r;
    item_nxt      = item_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    settle_nxt    = settle_r;
    set_ok_nxt    = set_ok_r;
    clear_nxt     = clear_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      cefs_pkg::S_IDLE: begin
        if (in_accept) begin
          item_nxt   = in_item;
          step_nxt   = '0;
          scan_nxt   = '0;
          match_nxt  = 1'b0;
          set_ok_nxt = 1'b0;
          clear_nxt  = 1'b0;
          if (in_tuser == cefs_pkg::OP_WRITE) begin
            state_nxt = cefs_pkg::S_SETPT;
          end else if (!cfg_charge_select_r) begin
            state_nxt = cefs_pkg::S_SCAN;
          end else begin
            // Manual tick: no scan, no sequencing.
            settle_nxt = '0;
            state_nxt  = cefs_pkg::S_SETPT;
          end
        end
      end

      cefs_pkg::S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (slot_hit) begin
          match_nxt = 1'b1;
        end
        if (scan_end) begin
          clear_nxt = any_match;
          if (any_match || (phase_r == cefs_pkg::PHASE_RESTART)) begin
            // Schedule match or restart phase: begin equalize on this same tick.
            phase_nxt  = cefs_pkg::PHASE_EQUALIZE;
            mode_nxt   = 1'b0;
            set_ok_nxt = 1'b1;
            settle_nxt = '0;
            state_nxt  = cefs_pkg::S_SETPT;
          end else if (phase_r == cefs_pkg::PHASE_EQUALIZE) begin
            state_nxt = cefs_pkg::S_EQ;
          end else begin
            settle_nxt = '0;
            state_nxt  = cefs_pkg::S_SETPT;
          end
        end
      end

      cefs_pkg::S_EQ: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = cefs_pkg::S_VCMP;
        end
      end

      cefs_pkg::S_VCMP: begin
        step_nxt = step_r + 1'b1;
        if (step_r == 2'd1) begin
          step_nxt  = '0;
          state_nxt = cefs_pkg::S_DECIDE;
        end
      end

      cefs_pkg::S_DECIDE: begin
        if ((settle_r == cefs_pkg::SETTLE_W'(cefs_pkg::SETTLE_TICKS)) && cut_ok) begin
          phase_nxt  = cefs_pkg::PHASE_FLOAT;
          mode_nxt   = 1'b1;
          set_ok_nxt = 1'b1;
        end else if (settle_r != cefs_pkg::SETTLE_W'(cefs_pkg::SETTLE_TICKS)) begin
          settle_nxt = settle_r + 1'b1;
        end
        state_nxt = cefs_pkg::S_SETPT;
      end

      cefs_pkg::S_SETPT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          step_nxt  = '0;
          state_nxt = cefs_pkg::S_DONE;
        end
      end

      cefs_pkg::S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {2'b00, clear_r, set_ok_r, phase_r, ~mode_r, mode_r,
                           cfg_charge_select_r, setpt_clamped};
          out_valid_nxt = 1'b1;
          state_nxt     = cefs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = cefs_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  // Results appear only from the result-load state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == cefs_pkg::S_DONE))
    else $error("result became valid outside the load state");

  // Float mode goes with the finished phase and nothing else.
  a_mode_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == (phase_r == cefs_pkg::PHASE_FLOAT))
    else $error("charge mode and phase disagree");

  // Settle count saturates at the settle length.
  a_settle_max: assert property (@(posedge clk) disable iff (!rst_n)
    settle_r <= cefs_pkg::SETTLE_W'(cefs_pkg::SETTLE_TICKS))
    else $error("settle count beyond its limit");

  // A timer clear only comes with a restart into equalize.
  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[21]) |->
      (out_tdata[20] && (out_tdata[19:18] == cefs_pkg::PHASE_EQUALIZE)))
    else $error("timer clear without equalize restart");

  // The scan never runs past the last slot.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cefs_pkg::S_SCAN) |-> (scan_r <= cefs_pkg::SCAN_W'(cefs_pkg::SLOTS)))
    else $error("schedule scan past the last slot");
`endif

endmodule

// ----- sv/cefs_mac.sv -----
// Shared signed multiply-accumulate unit of the sequencer.
// Depends on cefs_pkg (mac_ctl_t, widths).
module cefs_mac (
  input  logic                            clk,
  input  cefs_pkg::mac_ctl_t              ctl,
  output logic signed [cefs_pkg::ACC_W-1:0] acc
);

  localparam int PROD_W = cefs_pkg::OPND_W + cefs_pkg::COEF_W;

  logic signed [cefs_pkg::ACC_W-1:0] acc_r;
  logic signed [cefs_pkg::ACC_W-1:0] acc_nxt;
  logic signed [PROD_W-1:0]          prod;
  logic signed [cefs_pkg::ACC_W-1:0] base;

  assign prod    = PROD_W'(ctl.operand) * PROD_W'(ctl.coef);
  assign base    = ctl.clr ? '0 : acc_r;
  assign acc_nxt = base + cefs_pkg::ACC_W'(prod);

  // Accumulate only when the sequencer drives a step.
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule
